### rtl/core/swts_pkg.sv
// Shared types and field widths for the sliding-window temperature statistics block.
`timescale 1ns / 1ps

package swts_pkg;

  localparam int ZONE_W = 3;
  localparam int TEMP_W = 20;
  localparam int FILL_W = 5;

  typedef struct packed {
    logic [ZONE_W-1:0] zone;
    logic [TEMP_W-1:0] temperature;
  } sample_t;

  typedef struct packed {
    logic [TEMP_W-1:0] average;
    logic [TEMP_W-1:0] maximum;
    logic [FILL_W-1:0] fill_count;
  } result_t;

endpackage

### rtl/core/swts_divider.sv
// Restoring divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps

module swts_divider import swts_pkg::*; #(
  parameter int SUM_W = 25,
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [TEMP_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvs;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [CNT_W:0]    rem_shift;
  logic [CNT_W:0]    rem_diff;
  logic              fits;

  assign rem_shift = {rem, quo[SUM_W-1]};
  assign rem_diff  = rem_shift - {1'b0, dvs};
  assign fits      = rem_shift >= {1'b0, dvs};
  assign quotient  = quo[TEMP_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(SUM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[SUM_W-2:0], fits};
      rem <= fits ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
    end
  end

endmodule

### rtl/core/sliding_window_temp_stats.sv
// Top level: per-zone sample rings in memory, maximum scan and mean division.
`timescale 1ns / 1ps
//
// Takes one temperature request per zone on the sample channel (sample_valid,
// sample_stall, sample) and returns one result per request on the result
// channel (result_valid, result_stall, result) with the zone's mean, maximum
// and fill count after the new sample enters the ring.
// One request is in work at a time. The mean comes from the one-bit-per-cycle
// divider, whose dividend is SUM_W = 20 + clog2(WINDOW_DEPTH + 1) bits wide,
// and the maximum scan over the ring (one slot per cycle on the sample memory
// read port) runs beside it. sample_stall drops at the edge where the result
// enters the output register, so the next request can be taken from then on.
// A zone index of ZONE_COUNT or more changes nothing and returns all zeros.
// Reset clears the per-zone valid bits at once, so every zone starts empty;
// slots that were never written are never read for a result.
// While result_stall holds, the result register holds its value; the next
// request is accepted and worked on, and waits until the register empties.
//
module sliding_window_temp_stats import swts_pkg::*; #(
  parameter int WINDOW_DEPTH = 16,
  parameter int ZONE_COUNT   = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    sample_valid,
  output logic    sample_stall,
  input  sample_t sample,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int PW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW    = $clog2(WINDOW_DEPTH + 1);
  localparam int ZW    = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
  localparam int SUM_W = TEMP_W + CW;
  localparam int AW    = ZW + PW;
  localparam int ZTW   = PW + CW + SUM_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ZREAD,
    S_OLD,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;

  logic [TEMP_W-1:0] sample_mem [2**AW];
  logic [AW-1:0]     s_raddr;
  logic [TEMP_W-1:0] s_rdata;

  logic [ZTW-1:0]        zone_mem [ZONE_COUNT];
  logic [ZONE_COUNT-1:0] zone_vld;
  logic [ZW-1:0]         zt_raddr;
  logic [ZTW-1:0]        zt_rdata;
  logic                  zt_rvalid;
  logic [ZTW-1:0]        zt_wdata;

  logic [ZW-1:0]     zone_q;
  logic [TEMP_W-1:0] temp_q;
  logic [PW-1:0]     pos_q;
  logic [CW-1:0]     held_q;
  logic [SUM_W-1:0]  sum_q;
  logic [CW-1:0]     issue_idx;
  logic              pend;
  logic [TEMP_W-1:0] best;
  logic [TEMP_W-1:0] avg_q;
  logic              div_ok;

  logic              zone_ok;
  logic [PW-1:0]     ent_pos;
  logic [CW-1:0]     ent_held;
  logic [SUM_W-1:0]  ent_sum;
  logic              full;
  logic [TEMP_W-1:0] old_sample;
  logic [SUM_W-1:0]  sum_next;
  logic [CW-1:0]     held_next;
  logic [PW-1:0]     pos_next;
  logic              scan_done;
  logic              out_free;
  logic              res_load;
  logic              div_done;
  logic [TEMP_W-1:0] div_quo;

  assign sample_stall = (state != S_IDLE);
  assign zone_ok      = 32'(sample.zone) < ZONE_COUNT;
  assign zt_raddr     = ZW'(sample.zone);

  assign ent_pos  = zt_rvalid ? zt_rdata[ZTW-1 -: PW] : '0;
  assign ent_held = zt_rvalid ? zt_rdata[SUM_W+CW-1 -: CW] : '0;
  assign ent_sum  = zt_rvalid ? zt_rdata[SUM_W-1:0] : '0;

  assign full       = (held_q == CW'(WINDOW_DEPTH));
  assign old_sample = full ? s_rdata : '0;
  assign sum_next   = sum_q - SUM_W'(old_sample) + SUM_W'(temp_q);
  assign held_next  = full ? held_q : held_q + 1'b1;
  assign pos_next   = (pos_q == PW'(WINDOW_DEPTH - 1)) ? '0 : pos_q + 1'b1;
  assign zt_wdata   = {pos_next, held_next, sum_next};

  assign s_raddr   = (state == S_SCAN) ? {zone_q, issue_idx[PW-1:0]} : {zone_q, ent_pos};
  assign scan_done = (issue_idx == held_q) && !pend;
  assign out_free  = !result_valid || !result_stall;
  assign res_load  = (state == S_FINISH) && div_ok && out_free;

  always_ff @(posedge clk) begin
    if (state == S_OLD) begin
      sample_mem[{zone_q, pos_q}] <= temp_q;
    end
    s_rdata <= sample_mem[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == S_OLD) begin
      zone_mem[zone_q] <= zt_wdata;
    end
    zt_rdata <= zone_mem[zt_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_vld  <= '0;
      zt_rvalid <= 1'b0;
    end else begin
      if (state == S_OLD) begin
        zone_vld[zone_q] <= 1'b1;
      end
      zt_rvalid <= zone_vld[zt_raddr];
    end
  end

  swts_divider #(
    .SUM_W (SUM_W),
    .CNT_W (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_OLD),
    .dividend (sum_next),
    .divisor  (held_next),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      div_ok       <= 1'b0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (res_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (div_done) begin
        avg_q  <= div_quo;
        div_ok <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            zone_q <= ZW'(sample.zone);
            temp_q <= sample.temperature;
            if (zone_ok) begin
              div_ok <= 1'b0;
              state  <= S_ZREAD;
            end else begin
              avg_q  <= '0;
              best   <= '0;
              held_q <= '0;
              div_ok <= 1'b1;
              state  <= S_FINISH;
            end
          end
        end
        S_ZREAD: begin
          pos_q  <= ent_pos;
          held_q <= ent_held;
          sum_q  <= ent_sum;
          state  <= S_OLD;
        end
        S_OLD: begin
          held_q    <= held_next;
          issue_idx <= '0;
          pend      <= 1'b0;
          best      <= '0;
          state     <= S_SCAN;
        end
        S_SCAN: begin
          if (issue_idx != held_q) begin
            issue_idx <= issue_idx + 1'b1;
            pend      <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend && (s_rdata > best)) begin
            best <= s_rdata;
          end
          if (scan_done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (res_load) begin
            result.average    <= avg_q;
            result.maximum    <= best;
            result.fill_count <= FILL_W'(held_q);
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/swts_checker.sv
// Port-level checks for the sliding-window temperature statistics block, with its bind.
`timescale 1ns / 1ps

module swts_checker import swts_pkg::*; #(
  parameter int WINDOW_DEPTH = 16
) (
  input logic    clk,
  input logic    rst,
  input logic    sample_valid,
  input logic    sample_stall,
  input sample_t sample,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("second request taken while one is in work");

  a_empty_zone_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.fill_count == '0) |->
      (result.average == '0) && (result.maximum == '0))
    else $error("empty result carries statistics");

  a_mean_bounded: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.fill_count != '0) |->
      (result.average <= result.maximum) && (32'(result.fill_count) <= WINDOW_DEPTH))
    else $error("mean above maximum or fill count above depth");

endmodule

bind sliding_window_temp_stats swts_checker #(
  .WINDOW_DEPTH (WINDOW_DEPTH)
) u_swts_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .sample       (sample),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
